>>> hdl/ptf_pkg.sv
// Shared constants and the attenuation lookup for the PSG to FM register translator.
`default_nettype none
package ptf_pkg;

  localparam int unsigned DIVIDEND_W = 24;
  localparam int unsigned DIVISOR_W  = 12;
  localparam int unsigned CNT_W      = $clog2(DIVIDEND_W + 1);

  localparam logic [DIVIDEND_W-1:0] TONE_SCALE_RST = 24'd2345678;
  localparam logic [DIVIDEND_W-1:0] FNUM_LIMIT     = 24'h000400;

  localparam logic [3:0] REG_MIXER = 4'd7;

  localparam logic [7:0] FM_TONE_LO_BASE  = 8'hA0;
  localparam logic [7:0] FM_TONE_HI_BASE  = 8'hB0;
  localparam logic [7:0] FM_NOISE_LO      = 8'hA7;
  localparam logic [7:0] FM_NOISE_HI      = 8'hB7;
  localparam logic [7:0] FM_KEY_ON        = 8'h20;
  localparam logic [7:0] FM_TONE_LVL_BASE = 8'h43;
  localparam logic [7:0] FM_NOISE_LVL     = 8'h54;
  localparam logic [7:0] ATTEN_OFF        = 8'hFF;
  localparam logic [3:0] LEVEL_ENVELOPE   = 4'd12;

  function automatic logic [7:0] atten(input logic [3:0] level);
    logic [7:0] res;
    case (level)
      4'd0:    res = 8'hFF;
      4'd1:    res = 8'h3F;
      4'd2:    res = 8'h3F;
      4'd3:    res = 8'h3F;
      4'd4:    res = 8'h2C;
      4'd5:    res = 8'h26;
      4'd6:    res = 8'h22;
      4'd7:    res = 8'h1D;
      4'd8:    res = 8'h16;
      4'd9:    res = 8'h12;
      4'd10:   res = 8'h0C;
      4'd11:   res = 8'h0A;
      4'd12:   res = 8'h07;
      4'd13:   res = 8'h05;
      4'd14:   res = 8'h02;
      default: res = 8'h00;
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

>>> hdl/ptf_div.sv
// Radix-2 restoring divider, one quotient bit per clock.
`default_nettype none
module ptf_div (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic [ptf_pkg::DIVIDEND_W-1:0]    dividend,
  input  wire logic [ptf_pkg::DIVISOR_W-1:0]     divisor,
  output logic                                   done,
  output logic [ptf_pkg::DIVIDEND_W-1:0]         quotient
);

  logic [ptf_pkg::DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [ptf_pkg::DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [ptf_pkg::DIVISOR_W-1:0]  dvs_r, dvs_nxt;
  logic [ptf_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [ptf_pkg::DIVISOR_W:0]    trial;
  logic                           fits;

  assign trial = {rem_r, quo_r[ptf_pkg::DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = ptf_pkg::CNT_W'(ptf_pkg::DIVIDEND_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? ptf_pkg::DIVISOR_W'(trial - {1'b0, dvs_r})
                     : trial[ptf_pkg::DIVISOR_W-1:0];
      quo_nxt = {quo_r[ptf_pkg::DIVIDEND_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == ptf_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

>>> hdl/psg_to_fm_register_translator.sv
// Top level of the PSG to FM register translator: register file, sequencer and output register.
`default_nettype none
// Each accepted word is a write to one of the sixteen sound generator registers; the block
// stores it and produces zero to six FM register writes, the final one flagged by
// out_last_write. A tone period write goes through two register file reads, the shared
// divider (24 quotient bits, then a done strobe), one normalization step per octave (up
// to 14), the pick of the first slot, and the load of the first word; a zero period skips
// the divider. Further tone words follow back to back unless the output side stalls. An
// amplitude write reads its level register and loads two words, a mixer write does so for
// each of the three channels, and other registers only update the register file.
// in_stall stays high until the last FM word has been loaded into the output register.
module psg_to_fm_register_translator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_write_enable,
  input  wire logic [23:0] cfg_write_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  in_reg_index,
  input  wire logic [7:0]  in_reg_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_fm_address,
  output logic [7:0]       out_fm_data,
  output logic             out_last_write
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD_LO = 3'd1;
  localparam logic [2:0] S_RD_HI = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_NORM  = 3'd4;
  localparam logic [2:0] S_TONE  = 3'd5;
  localparam logic [2:0] S_VRD   = 3'd6;
  localparam logic [2:0] S_VOL   = 3'd7;

  logic [7:0]  regs_r [16];
  logic [23:0] scale_r;
  logic [2:0]  state_r, state_nxt;
  logic [1:0]  ch_r, ch_nxt;
  logic        mix_all_r, mix_all_nxt;
  logic [7:0]  lo_r, lo_nxt;
  logic [3:0]  hi_nib;
  logic [23:0] q_r, q_nxt;
  logic [3:0]  oct_r, oct_nxt;
  logic [1:0]  step_r, step_nxt;
  logic [3:0]  level_r, level_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_addr_r, out_addr_nxt;
  logic [7:0]  out_data_r, out_data_nxt;
  logic        out_last_r, out_last_nxt;

  logic        in_acc;
  logic        out_free;
  logic [3:0]  rd_addr;
  logic [7:0]  rd_data;
  logic [7:0]  mix;
  logic [2:0]  tone_off;
  logic [2:0]  noise_off;
  logic        div_start;
  logic        div_done;
  logic [23:0] div_quo;
  logic [7:0]  fnum_lo;
  logic [7:0]  fnum_hi;
  logic [7:0]  lvl_data;

  assign in_stall  = state_r != S_IDLE;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign mix       = regs_r[ptf_pkg::REG_MIXER];
  assign tone_off  = mix[2:0];
  assign noise_off = mix[5:3];
  assign rd_data   = regs_r[rd_addr];
  assign hi_nib    = rd_data[3:0];
  assign fnum_lo   = q_r[7:0];
  assign fnum_hi   = {2'b00, oct_r, 2'b00} | ptf_pkg::FM_KEY_ON | {6'b0, q_r[9:8]};
  assign lvl_data  = ptf_pkg::atten(level_r);

  always_comb begin
    case (state_r)
      S_RD_LO: rd_addr = {1'b0, ch_r, 1'b0};
      S_RD_HI: rd_addr = {1'b0, ch_r, 1'b1};
      S_VRD:   rd_addr = {2'b10, ch_r};
      default: rd_addr = ptf_pkg::REG_MIXER;
    endcase
  end

  ptf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (scale_r),
    .divisor  ({hi_nib, lo_r}),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    mix_all_nxt   = mix_all_r;
    lo_nxt        = lo_r;
    q_nxt         = q_r;
    oct_nxt       = oct_r;
    step_nxt      = step_r;
    level_nxt     = level_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_addr_nxt  = out_addr_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    div_start     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          mix_all_nxt = 1'b0;
          if (in_reg_index <= 4'd5) begin
            ch_nxt    = in_reg_index[2:1];
            state_nxt = S_RD_LO;
          end else if (in_reg_index == ptf_pkg::REG_MIXER) begin
            ch_nxt      = 2'd0;
            mix_all_nxt = 1'b1;
            state_nxt   = S_VRD;
          end else if (in_reg_index >= 4'd8 && in_reg_index <= 4'd10) begin
            ch_nxt    = in_reg_index[1:0];
            state_nxt = S_VRD;
          end
        end
      end
      S_RD_LO: begin
        lo_nxt    = rd_data;
        state_nxt = S_RD_HI;
      end
      S_RD_HI: begin
        oct_nxt = '0;
        if (hi_nib == 4'd0 && lo_r == 8'd0) begin
          q_nxt     = 24'd1;
          state_nxt = S_NORM;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          q_nxt     = div_quo;
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        if (q_r > ptf_pkg::FNUM_LIMIT) begin
          q_nxt   = q_r >> 1;
          oct_nxt = oct_r + 1'b1;
        end else if (!tone_off[ch_r]) begin
          step_nxt  = 2'd0;
          state_nxt = S_TONE;
        end else if (!noise_off[ch_r]) begin
          step_nxt  = 2'd2;
          state_nxt = S_TONE;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_TONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b0;
          case (step_r)
            2'd0: begin
              out_addr_nxt = ptf_pkg::FM_TONE_LO_BASE | {6'b0, ch_r};
              out_data_nxt = fnum_lo;
              step_nxt     = 2'd1;
            end
            2'd1: begin
              out_addr_nxt = ptf_pkg::FM_TONE_HI_BASE | {6'b0, ch_r};
              out_data_nxt = fnum_hi;
              if (noise_off[ch_r]) begin
                out_last_nxt = 1'b1;
                state_nxt    = S_IDLE;
              end else begin
                step_nxt = 2'd2;
              end
            end
            2'd2: begin
              out_addr_nxt = ptf_pkg::FM_NOISE_LO;
              out_data_nxt = fnum_lo;
              step_nxt     = 2'd3;
            end
            default: begin
              out_addr_nxt = ptf_pkg::FM_NOISE_HI;
              out_data_nxt = fnum_hi;
              out_last_nxt = 1'b1;
              state_nxt    = S_IDLE;
            end
          endcase
        end
      end
      S_VRD: begin
        level_nxt = rd_data[4] ? ptf_pkg::LEVEL_ENVELOPE : rd_data[3:0];
        step_nxt  = 2'd0;
        state_nxt = S_VOL;
      end
      S_VOL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b0;
          if (step_r == 2'd0) begin
            out_addr_nxt = ptf_pkg::FM_TONE_LVL_BASE + {6'b0, ch_r};
            out_data_nxt = tone_off[ch_r] ? ptf_pkg::ATTEN_OFF : lvl_data;
            step_nxt     = 2'd1;
          end else begin
            out_addr_nxt = ptf_pkg::FM_NOISE_LVL;
            out_data_nxt = (noise_off == 3'b111) ? ptf_pkg::ATTEN_OFF : lvl_data;
            if (mix_all_r && ch_r != 2'd2) begin
              ch_nxt    = ch_r + 1'b1;
              state_nxt = S_VRD;
            end else begin
              out_last_nxt = 1'b1;
              state_nxt    = S_IDLE;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        regs_r[i] <= '0;
      end
      scale_r     <= ptf_pkg::TONE_SCALE_RST;
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        regs_r[in_reg_index] <= in_reg_value;
      end
      if (cfg_write_enable) begin
        scale_r <= cfg_write_data;
      end
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r       <= ch_nxt;
    mix_all_r  <= mix_all_nxt;
    lo_r       <= lo_nxt;
    q_r        <= q_nxt;
    oct_r      <= oct_nxt;
    step_r     <= step_nxt;
    level_r    <= level_nxt;
    out_addr_r <= out_addr_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_fm_address = out_addr_r;
  assign out_fm_data    = out_data_r;
  assign out_last_write = out_last_r;

endmodule
`default_nettype wire

>>> tb/sv/tb_psg_to_fm_register_translator.sv
// Self-checking testbench for the PSG to FM register translator, with its own translation model.
module tb_psg_to_fm_register_translator;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    PSG_TONE_A_LO, PSG_TONE_A_HI, PSG_TONE_B_LO, PSG_TONE_B_HI,
    PSG_TONE_C_LO, PSG_TONE_C_HI, PSG_NOISE_PERIOD, PSG_MIXER,
    PSG_LEVEL_A, PSG_LEVEL_B, PSG_LEVEL_C, PSG_ENV_LO,
    PSG_ENV_HI, PSG_ENV_SHAPE, PSG_PORT_A, PSG_PORT_B
  } psg_reg_e;

  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] data;
    logic       last;
  } fm_write_t;

  typedef struct packed {
    logic [3:0] idx;
    logic [7:0] val;
    logic       typed;
    logic [2:0] n;
    fm_write_t  w0;
    fm_write_t  w1;
  } psg_write_row_t;

  localparam fm_write_t NO_WRITE    = '0;
  localparam int        GAP_PERCENT = 36;
  localparam int        SETTLE      = 100;
  localparam int        QUIET_LIMIT = 3000;
  localparam int        PHASES      = 6;
  localparam int        PHASE_ITEMS = 56;

  logic        clk;
  logic        rst_n            = 1'b0;
  logic        cfg_write_enable = 1'b0;
  logic [23:0] cfg_write_data   = '0;
  logic        in_valid         = 1'b0;
  logic        in_stall;
  logic [3:0]  in_reg_index     = '0;
  logic [7:0]  in_reg_value     = '0;
  logic        out_valid;
  logic        out_stall        = 1'b0;
  logic [7:0]  out_fm_address;
  logic [7:0]  out_fm_data;
  logic        out_last_write;

  logic        calm             = 1'b0;
  int          mismatch_count   = 0;
  int          quiet_cycles     = 0;

  logic [7:0]  psg_regs [16];
  logic [23:0] tone_scale_now;
  fm_write_t   fresh_writes [$];
  fm_write_t   fm_writes_due [$];

  logic [7:0] level_atten [16] = '{
    8'hFF, 8'h3F, 8'h3F, 8'h3F, 8'h2C, 8'h26, 8'h22, 8'h1D,
    8'h16, 8'h12, 8'h0C, 8'h0A, 8'h07, 8'h05, 8'h02, 8'h00
  };

  psg_write_row_t directed_writes [25] = '{
    '{PSG_LEVEL_A, 8'h00, 1'b1, 3'd2,
      '{ptf_pkg::FM_TONE_LVL_BASE, ptf_pkg::ATTEN_OFF, 1'b0},
      '{ptf_pkg::FM_NOISE_LVL, ptf_pkg::ATTEN_OFF, 1'b1}},
    '{PSG_LEVEL_B, 8'h1F, 1'b1, 3'd2, '{ptf_pkg::FM_TONE_LVL_BASE + 8'd1, 8'h07, 1'b0},
      '{ptf_pkg::FM_NOISE_LVL, 8'h07, 1'b1}},
    '{PSG_LEVEL_C, 8'h0F, 1'b1, 3'd2, '{ptf_pkg::FM_TONE_LVL_BASE + 8'd2, 8'h00, 1'b0},
      '{ptf_pkg::FM_NOISE_LVL, 8'h00, 1'b1}},
    '{PSG_NOISE_PERIOD, 8'hFF, 1'b1, 3'd0, NO_WRITE, NO_WRITE},
    '{PSG_TONE_A_LO, 8'h00, 1'b0, 3'd0, NO_WRITE, NO_WRITE},
    '{PSG_TONE_A_HI, 8'hFF, 1'b0, 3'd0, NO_WRITE, NO_WRITE},
    '{PSG_TONE_A_LO, 8'hFF, 1'b0, 3'd0, NO_WRITE, NO_WRITE},
    '{PSG_TONE_B_HI, 8'h00, 1'b0, 3'd0, NO_WRITE, NO_WRITE},
    '{PSG_TONE_B_LO, 8'h01, 1'b0, 3'd0, NO_WRITE, NO_WRITE},
    '{PSG_TONE_C_HI, 8'h0F, 1'b0, 3'd0, NO_WRITE, NO_WRITE},
    '{PSG_TONE_C_LO, 8'hFF, 1'b0, 3'd0, NO_WRITE, NO_WRITE},
    '{PSG_MIXER, 8'h00, 1'b0, 3'd0, NO_WRITE, NO_WRITE},
    '{PSG_MIXER, 8'h3F, 1'b0, 3'd0, NO_WRITE, NO_WRITE},
    '{PSG_TONE_A_LO, 8'h55, 1'b1, 3'd0, NO_WRITE, NO_WRITE},
    '{PSG_MIXER, 8'h09, 1'b0, 3'd0, NO_WRITE, NO_WRITE},
    '{PSG_TONE_B_LO, 8'h80, 1'b0, 3'd0, NO_WRITE, NO_WRITE},
    '{PSG_MIXER, 8'h38, 1'b0, 3'd0, NO_WRITE, NO_WRITE},
    '{PSG_LEVEL_A, 8'h10, 1'b0, 3'd0, NO_WRITE, NO_WRITE},
    '{PSG_LEVEL_B, 8'hE5, 1'b0, 3'd0, NO_WRITE, NO_WRITE},
    '{PSG_LEVEL_C, 8'hFF, 1'b0, 3'd0, NO_WRITE, NO_WRITE},
    '{PSG_ENV_LO, 8'hAA, 1'b1, 3'd0, NO_WRITE, NO_WRITE},
    '{PSG_ENV_HI, 8'h55, 1'b1, 3'd0, NO_WRITE, NO_WRITE},
    '{PSG_ENV_SHAPE, 8'hFF, 1'b1, 3'd0, NO_WRITE, NO_WRITE},
    '{PSG_PORT_A, 8'h00, 1'b1, 3'd0, NO_WRITE, NO_WRITE},
    '{PSG_PORT_B, 8'h80, 1'b1, 3'd0, NO_WRITE, NO_WRITE}
  };

  psg_to_fm_register_translator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_reg_index     (in_reg_index),
    .in_reg_value     (in_reg_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_fm_address   (out_fm_address),
    .out_fm_data      (out_fm_data),
    .out_last_write   (out_last_write)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic note_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  function automatic void queue_level_writes(input logic [1:0] ch);
    logic [7:0] amp;
    logic [3:0] level;
    logic [7:0] tone_lvl;
    logic [7:0] noise_lvl;
    amp = psg_regs[PSG_LEVEL_A + ch];
    level = amp[4] ? ptf_pkg::LEVEL_ENVELOPE : amp[3:0];
    tone_lvl = psg_regs[ptf_pkg::REG_MIXER][ch] ? ptf_pkg::ATTEN_OFF : level_atten[level];
    noise_lvl = (psg_regs[ptf_pkg::REG_MIXER][5:3] == 3'b111) ? ptf_pkg::ATTEN_OFF
                                                               : level_atten[level];
    fresh_writes.push_back('{8'(ptf_pkg::FM_TONE_LVL_BASE + ch), tone_lvl, 1'b0});
    fresh_writes.push_back('{ptf_pkg::FM_NOISE_LVL, noise_lvl, 1'b0});
  endfunction

  // Updates the register file copy and works out the FM words that the write produces.
  function automatic void translate_psg_write(input logic [3:0] idx, input logic [7:0] val,
                                              input bit keep);
    logic [1:0]  ch;
    logic [11:0] period;
    int unsigned quot;
    int unsigned octave;
    logic [7:0]  lo;
    logic [7:0]  hi;
    fresh_writes.delete();
    psg_regs[idx] = val;
    if (idx <= PSG_TONE_C_HI) begin
      ch = idx[2:1];
      period = {psg_regs[{ch, 1'b1}][3:0], psg_regs[{ch, 1'b0}]};
      quot = (period == 12'd0) ? 1 : tone_scale_now / period;
      octave = 0;
      while (quot > ptf_pkg::FNUM_LIMIT) begin
        quot = quot >> 1;
        octave++;
      end
      lo = quot[7:0];
      hi = 8'(((quot >> 8) & 3) | (octave << 2) | ptf_pkg::FM_KEY_ON);
      if (!psg_regs[ptf_pkg::REG_MIXER][ch]) begin
        fresh_writes.push_back('{8'(ptf_pkg::FM_TONE_LO_BASE + ch), lo, 1'b0});
        fresh_writes.push_back('{8'(ptf_pkg::FM_TONE_HI_BASE + ch), hi, 1'b0});
      end
      if (!psg_regs[ptf_pkg::REG_MIXER][ch + 3]) begin
        fresh_writes.push_back('{ptf_pkg::FM_NOISE_LO, lo, 1'b0});
        fresh_writes.push_back('{ptf_pkg::FM_NOISE_HI, hi, 1'b0});
      end
    end else if (idx == ptf_pkg::REG_MIXER) begin
      for (int c = 0; c < 3; c++) queue_level_writes(2'(c));
    end else if (idx >= PSG_LEVEL_A && idx <= PSG_LEVEL_C) begin
      queue_level_writes(2'(idx - PSG_LEVEL_A));
    end
    if (fresh_writes.size() != 0) fresh_writes[fresh_writes.size() - 1].last = 1'b1;
    if (keep) begin
      foreach (fresh_writes[k]) fm_writes_due.push_back(fresh_writes[k]);
    end
  endfunction

  // Returns at the edge where the word was taken, leaving in_valid as it is.
  task automatic drive_psg_write(input logic [3:0] idx, input logic [7:0] val);
    while (!calm && $urandom_range(0, 99) < GAP_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_reg_index <= idx;
    in_reg_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic load_tone_scale(input logic [23:0] scale);
    in_valid <= 1'b0;
    while (fm_writes_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_write_enable <= 1'b1;
    cfg_write_data <= scale;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    tone_scale_now = scale;
  endtask

  always @(posedge clk) begin : fm_side
    fm_write_t want;
    out_stall <= !calm && ($urandom_range(0, 99) < GAP_PERCENT);
    if (rst_n && out_valid && !out_stall) begin
      if (fm_writes_due.size() == 0) begin
        note_mismatch($sformatf("unexpected FM word %h=%h last %b",
                                out_fm_address, out_fm_data, out_last_write));
      end else begin
        want = fm_writes_due.pop_front();
        if (out_fm_address !== want.addr)
          note_mismatch($sformatf("address %h, expected %h", out_fm_address, want.addr));
        if (out_fm_data !== want.data)
          note_mismatch($sformatf("data %h at %h, expected %h", out_fm_data, want.addr,
                                  want.data));
        if (out_last_write !== want.last)
          note_mismatch($sformatf("last %b at %h, expected %b", out_last_write, want.addr,
                                  want.last));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [23:0] scale;
    logic [3:0]  idx;
    logic [7:0]  val;
    int          pick;
    int          counted;
    int          p;
    for (int r = 0; r < 16; r++) psg_regs[r] = 8'h00;
    tone_scale_now = ptf_pkg::TONE_SCALE_RST;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_writes[i]) begin
      drive_psg_write(directed_writes[i].idx, directed_writes[i].val);
      translate_psg_write(directed_writes[i].idx, directed_writes[i].val,
                          !directed_writes[i].typed);
      if (directed_writes[i].typed) begin
        if (directed_writes[i].n > 0) fm_writes_due.push_back(directed_writes[i].w0);
        if (directed_writes[i].n > 1) fm_writes_due.push_back(directed_writes[i].w1);
      end
    end

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0:       scale = 24'd1;
        1:       scale = 24'hFFFFFF;
        2:       scale = 24'd0;
        3:       scale = 24'($urandom_range(0, 24'hFFFFFF));
        4:       scale = 24'($urandom_range(1, 4095));
        default: scale = ptf_pkg::TONE_SCALE_RST;
      endcase
      load_tone_scale(scale);
      calm <= (p == 3);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          idx = 4'($urandom_range(PSG_TONE_A_LO, PSG_TONE_C_HI));
        end else if (pick < 60) begin
          idx = ptf_pkg::REG_MIXER;
        end else if (pick < 85) begin
          idx = 4'($urandom_range(PSG_LEVEL_A, PSG_LEVEL_C));
        end else begin
          pick = $urandom_range(0, 5);
          idx = (pick == 0) ? PSG_NOISE_PERIOD : 4'(PSG_LEVEL_C + pick);
        end
        val = 8'($urandom_range(0, 255));
        drive_psg_write(idx, val);
        translate_psg_write(idx, val, 1'b1);
        counted++;
      end
    end

    in_valid <= 1'b0;
    calm <= 1'b0;
    while (fm_writes_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
